// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== design/spas_pkg.sv =====
// types, codes and constants of the sparse polynomial add/subtract block
package spas_pkg;

    localparam int MAX_TERMS_DEFAULT = 32;

    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_ADD         = 2'd2;
    localparam logic [1:0] MODE_SUB         = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] term_coefficient;
        logic [9:0]         term_exponent;
        logic               term_last;
    } item_t;

    typedef struct packed {
        logic signed [16:0] out_coefficient;
        logic [9:0]         out_exponent;
        logic               out_last;
        logic               out_empty;
        logic               out_overflow;
    } result_t;

    typedef struct packed {
        logic signed [15:0] coefficient;
        logic [9:0]         exponent;
    } term_t;

    typedef struct packed {
        logic latch;
        logic ld_prep;
        logic ins_read;
        logic ins_shift;
        logic ins_put;
        logic mg_start;
        logic mg_read;
        logic mg_emit;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic do_insert;
        logic ptr_zero;
        logic shift_more;
        logic both_empty;
        logic mg_final;
    } sts_t;

endpackage

// ===== design/spas_ctrl.sv =====
// controller state machine for load insertion and merge sequencing
`include "assert_macros.svh"

module spas_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  spas_pkg::sts_t sts,
    output spas_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_MG_RD,
        S_MG_EMIT,
        S_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;

    assign out_free     = !result_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_load)
                begin
                    cmd.ld_prep = 1'b1;
                    state_next  = sts.do_insert ? S_INS_RD : S_IDLE;
                end
                else if (sts.both_empty)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    cmd.mg_start = 1'b1;
                    state_next   = S_MG_RD;
                end
            end
            S_INS_RD:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.shift_more)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_RD;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MG_RD:
            begin
                cmd.mg_read = 1'b1;
                state_next  = S_MG_EMIT;
            end
            S_MG_EMIT:
            begin
                if (out_free)
                begin
                    cmd.mg_emit       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = sts.mg_final ? S_IDLE : S_MG_RD;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    cmd.emit_empty    = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    `ASSERT_NEVER(a_emit_overwrite, clk, rst_n, (cmd.mg_emit || cmd.emit_empty) && result_valid && result_stall)
    `ASSERT_CLK(a_busy_after_transfer, clk, rst_n, (item_valid && !item_stall) |=> item_stall)

endmodule

// ===== design/spas_dp.sv =====
// datapath: term stores, counts, flags, merge arithmetic and result register
`include "assert_macros.svh"

module spas_dp #(
    parameter int MAX_TERMS = spas_pkg::MAX_TERMS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spas_pkg::item_t   item,
    input  spas_pkg::cmd_t    cmd,
    output spas_pkg::sts_t    sts,
    output spas_pkg::result_t result
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    spas_pkg::term_t   first_terms_reg  [MAX_TERMS];
    spas_pkg::term_t   second_terms_reg [MAX_TERMS];
    spas_pkg::term_t   rd1_reg;
    spas_pkg::term_t   rd2_reg;
    spas_pkg::item_t   item_reg;
    spas_pkg::result_t result_reg;

    logic [CNT_W-1:0] first_count_reg;
    logic [CNT_W-1:0] second_count_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] j_reg;
    logic [1:0]       restart_reg;
    logic             dropped_reg;

    logic             sel;
    logic             coef_nonzero;
    logic [CNT_W-1:0] sel_count;
    logic [CNT_W-1:0] eff_n;
    logic             store_full;
    logic [CNT_W-1:0] ptr_dec;
    logic [IDX_W-1:0] rd1_addr;
    logic [IDX_W-1:0] rd2_addr;
    logic [IDX_W-1:0] wr_addr;
    spas_pkg::term_t  rd_sel;
    spas_pkg::term_t  new_term;
    spas_pkg::term_t  wr_data;
    logic             wr_first;
    logic             wr_second;

    logic               a_ok;
    logic               b_ok;
    logic               take_a;
    logic               combine;
    logic signed [16:0] ca_ext;
    logic signed [16:0] cb_ext;
    logic signed [16:0] res_coef;
    logic [9:0]         res_exp;
    logic [CNT_W-1:0]   i_next;
    logic [CNT_W-1:0]   j_next;
    logic               mg_final;

    assign sel          = item_reg.mode[0];
    assign coef_nonzero = (item_reg.term_coefficient != 16'sd0);
    assign sel_count    = sel ? second_count_reg : first_count_reg;
    assign eff_n        = restart_reg[sel] ? '0 : sel_count;
    assign store_full   = !(32'(eff_n) < MAX_TERMS);
    assign ptr_dec      = ptr_reg - CNT_W'(1);
    assign rd1_addr     = cmd.mg_read ? ptr_reg[IDX_W-1:0] : ptr_dec[IDX_W-1:0];
    assign rd2_addr     = cmd.mg_read ? j_reg[IDX_W-1:0] : ptr_dec[IDX_W-1:0];
    assign wr_addr      = ptr_reg[IDX_W-1:0];
    assign rd_sel       = sel ? rd2_reg : rd1_reg;
    assign new_term     = '{coefficient: item_reg.term_coefficient,
                            exponent: item_reg.term_exponent};
    assign wr_data      = cmd.ins_shift ? rd_sel : new_term;
    assign wr_first     = (cmd.ins_shift || cmd.ins_put) && !sel;
    assign wr_second    = (cmd.ins_shift || cmd.ins_put) && sel;

    // merge step on the two words registered by the last merge read
    always_comb
    begin
        a_ok    = (ptr_reg < first_count_reg);
        b_ok    = (j_reg < second_count_reg);
        take_a  = !b_ok || (a_ok && (rd1_reg.exponent > rd2_reg.exponent));
        combine = !take_a && a_ok && (rd1_reg.exponent == rd2_reg.exponent);
        ca_ext  = {rd1_reg.coefficient[15], rd1_reg.coefficient};
        cb_ext  = {rd2_reg.coefficient[15], rd2_reg.coefficient};
        if (item_reg.mode == spas_pkg::MODE_SUB)
        begin
            cb_ext = -cb_ext;
        end
        if (take_a)
        begin
            res_coef = ca_ext;
            res_exp  = rd1_reg.exponent;
        end
        else
        begin
            res_coef = combine ? (ca_ext + cb_ext) : cb_ext;
            res_exp  = rd2_reg.exponent;
        end
        i_next   = ptr_reg + CNT_W'(take_a || combine);
        j_next   = j_reg + CNT_W'(!take_a);
        mg_final = !(i_next < first_count_reg) && !(j_next < second_count_reg);
    end

    always_comb
    begin
        sts.is_load    = (item_reg.mode == spas_pkg::MODE_LOAD_FIRST)
                      || (item_reg.mode == spas_pkg::MODE_LOAD_SECOND);
        sts.do_insert  = coef_nonzero && !store_full;
        sts.ptr_zero   = (ptr_reg == '0);
        sts.shift_more = (rd_sel.exponent < item_reg.term_exponent);
        sts.both_empty = (first_count_reg == '0) && (second_count_reg == '0);
        sts.mg_final   = mg_final;
    end

    // term stores
    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            first_terms_reg[wr_addr] <= wr_data;
        end
        if (wr_second)
        begin
            second_terms_reg[wr_addr] <= wr_data;
        end
        if (cmd.ins_read || cmd.mg_read)
        begin
            rd1_reg <= first_terms_reg[rd1_addr];
            rd2_reg <= second_terms_reg[rd2_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.mg_emit)
        begin
            result_reg <= '{out_coefficient: res_coef, out_exponent: res_exp,
                            out_last: mg_final, out_empty: 1'b0,
                            out_overflow: dropped_reg};
        end
        else if (cmd.emit_empty)
        begin
            result_reg <= '{out_coefficient: 17'sd0, out_exponent: 10'd0,
                            out_last: 1'b1, out_empty: 1'b1,
                            out_overflow: dropped_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            ptr_reg          <= '0;
            j_reg            <= '0;
            restart_reg      <= '0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.ld_prep)
            begin
                if (sel)
                begin
                    second_count_reg <= eff_n;
                end
                else
                begin
                    first_count_reg <= eff_n;
                end
                restart_reg[sel] <= item_reg.term_last;
                ptr_reg          <= eff_n;
                if (coef_nonzero && store_full)
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.ins_shift)
            begin
                ptr_reg <= ptr_dec;
            end
            if (cmd.ins_put)
            begin
                if (sel)
                begin
                    second_count_reg <= second_count_reg + CNT_W'(1);
                end
                else
                begin
                    first_count_reg <= first_count_reg + CNT_W'(1);
                end
            end
            if (cmd.mg_start)
            begin
                ptr_reg <= '0;
                j_reg   <= '0;
            end
            if (cmd.mg_emit)
            begin
                ptr_reg <= i_next;
                j_reg   <= j_next;
            end
        end
    end

    assign result = result_reg;

    `ASSERT_NEVER(a_count_range, clk, rst_n, (32'(first_count_reg) > MAX_TERMS) || (32'(second_count_reg) > MAX_TERMS))
    `ASSERT_NEVER(a_shift_at_zero, clk, rst_n, cmd.ins_shift && (ptr_reg == '0))

endmodule

// ===== design/sparse_polynomial_add_sub.sv =====
// load: an unstored term returns to idle after decode; else each stored term of lower exponent
// moves up by one registered store read and one write, then the new term is put, with no read when it lands first
// add/subtract: a merge read then an emit per result term, or one empty result when both stores are empty;
// each emit waits while the output is stalled; a command gives up to 2*MAX_TERMS result transfers;
// only one item is in work at a time; a finished result waits in the output register while the next item is taken
// reset clears counts, restart bits and the overflow flag; store contents are not cleared
module sparse_polynomial_add_sub #(
    parameter int MAX_TERMS = spas_pkg::MAX_TERMS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  spas_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output spas_pkg::result_t result
);

    spas_pkg::cmd_t cmd;
    spas_pkg::sts_t sts;

    spas_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    spas_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

// ===== dv/tb_sparse_polynomial_add_sub.sv =====
// testbench for sparse_polynomial_add_sub: directed and random loads and merges, checked in order
module tb_sparse_polynomial_add_sub;
    import spas_pkg::*;

    localparam int CAPACITY    = MAX_TERMS_DEFAULT;
    localparam int FIRST_POLY  = 0;
    localparam int SECOND_POLY = 1;
    localparam int QUIET_LIMIT = 4000;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    term_t   poly_store [2][CAPACITY];
    int      poly_count [2];
    logic    restart_pending [2];
    logic    dropped_terms;
    result_t expected_terms [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int commands_sent = 0;
    int results_seen  = 0;
    int failures      = 0;
    int quiet_cycles  = 0;

    sparse_polynomial_add_sub DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            results_seen++;
            if (expected_terms.size() == 0)
            begin
                $error("unexpected result transfer: out_coefficient %0d out_exponent %0d",
                       result.out_coefficient, result.out_exponent);
                failures++;
            end
            else
            begin
                want = expected_terms.pop_front();
                if (result.out_coefficient !== want.out_coefficient)
                begin
                    $error("out_coefficient: expected %0d, got %0d",
                           want.out_coefficient, result.out_coefficient);
                    failures++;
                end
                if (result.out_exponent !== want.out_exponent)
                begin
                    $error("out_exponent: expected %0d, got %0d",
                           want.out_exponent, result.out_exponent);
                    failures++;
                end
                if (result.out_last !== want.out_last)
                begin
                    $error("out_last: expected %0b, got %0b", want.out_last, result.out_last);
                    failures++;
                end
                if (result.out_empty !== want.out_empty)
                begin
                    $error("out_empty: expected %0b, got %0b", want.out_empty, result.out_empty);
                    failures++;
                end
                if (result.out_overflow !== want.out_overflow)
                begin
                    $error("out_overflow: expected %0b, got %0b",
                           want.out_overflow, result.out_overflow);
                    failures++;
                end
            end
        end
    end

    task automatic predict_transfer(input item_t it);
        int      sel;
        int      pos;
        int      i;
        int      j;
        int      sum;
        result_t r;
        if (it.mode == MODE_LOAD_FIRST || it.mode == MODE_LOAD_SECOND)
        begin
            sel = (it.mode == MODE_LOAD_SECOND) ? SECOND_POLY : FIRST_POLY;
            if (restart_pending[sel])
            begin
                poly_count[sel] = 0;
                restart_pending[sel] = 1'b0;
            end
            if (it.term_coefficient != 0)
            begin
                if (poly_count[sel] >= CAPACITY)
                begin
                    dropped_terms = 1'b1;
                end
                else
                begin
                    pos = 0;
                    while (pos < poly_count[sel]
                           && poly_store[sel][pos].exponent >= it.term_exponent)
                        pos++;
                    for (i = poly_count[sel]; i > pos; i--)
                        poly_store[sel][i] = poly_store[sel][i - 1];
                    poly_store[sel][pos].coefficient = it.term_coefficient;
                    poly_store[sel][pos].exponent    = it.term_exponent;
                    poly_count[sel]++;
                end
            end
            if (it.term_last)
                restart_pending[sel] = 1'b1;
        end
        else if (poly_count[FIRST_POLY] == 0 && poly_count[SECOND_POLY] == 0)
        begin
            r = '0;
            r.out_last     = 1'b1;
            r.out_empty    = 1'b1;
            r.out_overflow = dropped_terms;
            expected_terms.push_back(r);
        end
        else
        begin
            i = 0;
            j = 0;
            while (i < poly_count[FIRST_POLY] || j < poly_count[SECOND_POLY])
            begin
                r = '0;
                r.out_overflow = dropped_terms;
                if (j >= poly_count[SECOND_POLY] || (i < poly_count[FIRST_POLY]
                    && poly_store[FIRST_POLY][i].exponent > poly_store[SECOND_POLY][j].exponent))
                begin
                    sum = $signed(poly_store[FIRST_POLY][i].coefficient);
                    r.out_exponent = poly_store[FIRST_POLY][i].exponent;
                    i++;
                end
                else
                begin
                    sum = $signed(poly_store[SECOND_POLY][j].coefficient);
                    if (it.mode == MODE_SUB)
                        sum = -sum;
                    r.out_exponent = poly_store[SECOND_POLY][j].exponent;
                    if (i < poly_count[FIRST_POLY]
                        && poly_store[FIRST_POLY][i].exponent == r.out_exponent)
                    begin
                        sum += $signed(poly_store[FIRST_POLY][i].coefficient);
                        i++;
                    end
                    j++;
                end
                r.out_coefficient = sum[16:0];
                r.out_last = (i >= poly_count[FIRST_POLY] && j >= poly_count[SECOND_POLY]);
                expected_terms.push_back(r);
            end
        end
    endtask

    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall !== 1'b0);
        predict_transfer(it);
        items_sent++;
        if (it.mode == MODE_ADD || it.mode == MODE_SUB)
            commands_sent++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_terms.size() != 0);
    endtask

    function automatic item_t make_item(input logic [1:0] mode, input logic signed [15:0] coef,
                                        input logic [9:0] expo, input logic last);
        item_t it;
        it.mode             = mode;
        it.term_coefficient = coef;
        it.term_exponent    = expo;
        it.term_last        = last;
        return it;
    endfunction

    function automatic item_t random_term(input logic [1:0] mode, input logic last,
                                          input logic narrow);
        item_t it;
        int    pick;
        int    sel;
        pick = $urandom_range(99);
        it.mode             = mode;
        it.term_coefficient = 16'($urandom_range(16'hffff));
        it.term_exponent    = narrow ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
        it.term_last        = last;
        if (pick < 10)
            it.term_coefficient = '0;
        else if (pick < 14)
            it.term_coefficient = 16'sh7fff;
        else if (pick < 18)
            it.term_coefficient = 16'sh8000;
        else if (pick < 22)
            it.term_exponent = pick[0] ? 10'h3ff : 10'h000;
        // keep stores below capacity until the overflow test
        if (mode == MODE_LOAD_FIRST || mode == MODE_LOAD_SECOND)
        begin
            sel = (mode == MODE_LOAD_SECOND) ? SECOND_POLY : FIRST_POLY;
            if (!restart_pending[sel] && poly_count[sel] >= CAPACITY - 2)
                it.term_last = 1'b1;
        end
        return it;
    endfunction

    task automatic load_poly(input logic [1:0] mode, input int len, input logic narrow);
        int k;
        for (k = 0; k < len; k++)
            send_item(random_term(mode, k == len - 1, narrow));
    endtask

    task automatic test_empty_commands();
        send_item(make_item(MODE_ADD, -16'sd1, 10'h3ff, 1'b1));
        send_item(make_item(MODE_SUB, 16'sd0, 10'h000, 1'b0));
    endtask

    task automatic test_extreme_merge();
        send_item(make_item(MODE_LOAD_FIRST, 16'sh7fff, 10'h3ff, 1'b0));
        send_item(make_item(MODE_LOAD_FIRST, 16'sh8000, 10'h000, 1'b0));
        send_item(make_item(MODE_LOAD_FIRST, 16'sd0, 10'd512, 1'b0));
        send_item(make_item(MODE_LOAD_FIRST, 16'sd5, 10'h3ff, 1'b1));
        send_item(make_item(MODE_LOAD_SECOND, 16'sh8000, 10'h3ff, 1'b0));
        send_item(make_item(MODE_LOAD_SECOND, 16'sd1, 10'h000, 1'b0));
        send_item(make_item(MODE_LOAD_SECOND, 16'sd7, 10'd600, 1'b1));
        send_item(make_item(MODE_SUB, 16'sh5555, 10'h2aa, 1'b1));
        send_item(make_item(MODE_ADD, 16'sh2aaa, 10'h155, 1'b0));
    endtask

    task automatic test_restart_and_cancel();
        send_item(make_item(MODE_LOAD_FIRST, 16'sd3, 10'd20, 1'b0));
        send_item(make_item(MODE_LOAD_FIRST, 16'sd0, 10'd7, 1'b1));
        send_item(make_item(MODE_LOAD_SECOND, -16'sd3, 10'd20, 1'b1));
        send_item(make_item(MODE_ADD, 16'sd0, 10'd0, 1'b0));
        send_item(make_item(MODE_LOAD_FIRST, 16'sd9, 10'd4, 1'b1));
        send_item(make_item(MODE_SUB, 16'sd0, 10'd0, 1'b0));
        send_item(make_item(MODE_LOAD_SECOND, 16'sd0, 10'd0, 1'b1));
        send_item(make_item(MODE_ADD, 16'sd0, 10'd0, 1'b0));
        send_item(make_item(MODE_LOAD_FIRST, 16'sd0, 10'd0, 1'b1));
        send_item(make_item(MODE_SUB, 16'sd0, 10'd0, 1'b0));
        send_item(make_item(MODE_LOAD_SECOND, -16'sd1, 10'h3ff, 1'b0));
        send_item(make_item(MODE_SUB, 16'sd0, 10'd0, 1'b0));
    endtask

    task automatic test_random(input int n_items, input int sender_pct, input int receiver_pct);
        int   stop_at;
        int   len;
        logic narrow;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 75)
            begin
                narrow = 1'($urandom_range(1));
                if ($urandom_range(3) != 0)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
                    load_poly(MODE_LOAD_FIRST, len, narrow);
                end
                if ($urandom_range(3) != 0)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
                    load_poly(MODE_LOAD_SECOND, len, narrow);
                end
                send_item(random_term($urandom_range(1) ? MODE_ADD : MODE_SUB,
                                      1'($urandom_range(1)), narrow));
            end
            else
            begin
                send_item(random_term(2'($urandom_range(3)), $urandom_range(3) == 0,
                                      1'($urandom_range(1))));
            end
        end
    endtask

    task automatic test_overflow();
        int k;
        for (k = 0; k <= CAPACITY; k++)
            send_item(make_item(MODE_LOAD_FIRST, 16'($urandom_range(1, 32767)),
                                10'(2 * k), k == CAPACITY));
        for (k = 0; k <= CAPACITY; k++)
            send_item(make_item(MODE_LOAD_SECOND, -16'($urandom_range(1, 32767)),
                                10'(2 * k + 1), k == CAPACITY));
        send_item(make_item(MODE_ADD, 16'sd0, 10'd0, 1'b0));
        send_item(make_item(MODE_SUB, 16'sd0, 10'd0, 1'b0));
    endtask

    initial
    begin
        poly_count[FIRST_POLY]       = 0;
        poly_count[SECOND_POLY]      = 0;
        restart_pending[FIRST_POLY]  = 1'b0;
        restart_pending[SECOND_POLY] = 1'b0;
        dropped_terms                = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 8;
        recv_idle_pct = 83;
        test_empty_commands();
        test_extreme_merge();
        test_restart_and_cancel();
        test_random(100, 8, 83);
        drain_results();
        test_random(100, 83, 8);
        drain_results();
        test_random(90, 0, 0);
        test_overflow();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_terms.size() != 0);
        repeat (2 * CAPACITY + 20) @(posedge clk);
        $display("tb: %0d input transfers (%0d add/subtract commands), %0d result transfers checked",
                 items_sent, commands_sent, results_seen);
        $display("tb: empty stores, extreme coefficients, ties, cancellation, restarts, %s",
                 "full-store drops and three idle profiles");
        if (failures == 0 && expected_terms.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
